[rtl/uofv_pkg.sv]
// uofv_pkg: types, codes and byte classifiers for the origin-form target checker
// no dependencies; imported by uofv_parse_core and uri_origin_form_validator
package uofv_pkg;

  localparam int CFG_W = 14;
  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 14'd8192;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_PATH  = 3'd1,
    ST_QUERY = 3'd2,
    ST_HEX1  = 3'd3,
    ST_HEX2  = 3'd4,
    ST_DONE  = 3'd5,
    ST_BAD   = 3'd6,
    ST_LONG  = 3'd7
  } parse_state_t;

  typedef enum logic [2:0] {
    STAT_RUN     = 3'd0,
    STAT_DONE    = 3'd1,
    STAT_INVALID = 3'd2,
    STAT_TOOLONG = 3'd3,
    STAT_EXTRA   = 3'd4
  } status_t;

  typedef struct packed {
    parse_state_t pstate;
    logic         query;
    logic         slash;
    logic [3:0]   hi_nib;
  } parse_ctx_t;

  typedef struct packed {
    status_t    status;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       in_query;
  } parse_res_t;

  localparam parse_ctx_t CTX_CLEAR = '{pstate: ST_START, query: 1'b0, slash: 1'b0,
                                       hi_nib: 4'd0};

  function automatic logic is_pchar(input logic [7:0] c);
    logic r;
    r = 1'b0;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A)) begin
      r = 1'b1;
    end else begin
      case (c)
        8'h2D, 8'h2E, 8'h5F, 8'h7E,
        8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
        8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D,
        8'h3A, 8'h40: r = 1'b1;
        default:      r = 1'b0;
      endcase
    end
    return r;
  endfunction

  // {ok, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

[rtl/uri_origin_form_validator.sv]
// origin-form request-target checker with percent decoding
// the result word is registered and valid in the cycle after its input word is accepted
// throughput: one word per clock; the parse context loop through uofv_parse_core
//   is registered in ctx_r; input stalls while a result word waits unaccepted
// reset (rst_n low, synchronous): parser in start state, count 0, max_length 8192
// depends on uofv_pkg and uofv_parse_core
module uri_origin_form_validator import uofv_pkg::*; #(
  parameter int COUNT_WIDTH = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_ch,
  input  logic             in_start_of_target,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output logic             out_byte_valid,
  output logic [7:0]       out_data_byte,
  output logic             out_in_query,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_max_length
);

  localparam int LW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  parse_ctx_t             ctx_r, ctx_cur, ctx_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_cur;
  logic [CFG_W-1:0]       max_len_r;
  logic                   out_valid_r;
  parse_res_t             res_r, res_nxt;
  logic [LW-1:0]          cnt_ext, lim_ext, cnt_mask, limit;
  logic                   at_limit, count_en, in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // start mark restarts the parser before the word is taken
  assign ctx_cur   = in_start_of_target ? CTX_CLEAR : ctx_r;
  assign count_cur = in_start_of_target ? '0 : count_r;

  assign cnt_ext  = LW'(count_cur);
  assign lim_ext  = LW'(max_len_r);
  assign cnt_mask = LW'({COUNT_WIDTH{1'b1}});
  assign limit    = (lim_ext < cnt_mask) ? lim_ext : cnt_mask;
  assign at_limit = (cnt_ext >= limit);

  uofv_parse_core u_core (
    .cur      (ctx_cur),
    .ch       (in_ch),
    .at_limit (at_limit),
    .nxt      (ctx_nxt),
    .res      (res_nxt),
    .count_en (count_en)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r       <= CTX_CLEAR;
      count_r     <= '0;
      max_len_r   <= MAX_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_len_r <= cfg_max_length;
      end
      if (in_fire) begin
        ctx_r   <= ctx_nxt;
        count_r <= count_en ? count_cur + 1'b1 : count_cur;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = res_r.status;
  assign out_byte_valid = res_r.byte_valid;
  assign out_data_byte  = res_r.data_byte;
  assign out_in_query   = res_r.in_query;

endmodule

[rtl/uofv_parse_core.sv]
// uofv_parse_core: per-byte parse step, next context and result word
// depends on uofv_pkg; purely combinational, registered by the top level
module uofv_parse_core import uofv_pkg::*; (
  input  parse_ctx_t cur,
  input  logic [7:0] ch,
  input  logic       at_limit,
  output parse_ctx_t nxt,
  output parse_res_t res,
  output logic       count_en
);

  logic       terminal;
  logic       ends;
  logic [4:0] hex;
  logic       pchar;

  assign terminal = (cur.pstate == ST_DONE) || (cur.pstate == ST_BAD) ||
                    (cur.pstate == ST_LONG);
  assign ends = ((cur.pstate == ST_PATH) && (ch == CH_NUL)) ||
                ((cur.pstate == ST_QUERY) && ((ch == CH_NUL) || (ch == CH_HASH)));
  assign hex      = hex_decode(ch);
  assign pchar    = is_pchar(ch);
  assign count_en = !terminal && !ends && !at_limit;

  // next state
  always_comb begin
    nxt = cur;
    if (!terminal) begin
      if (ends) begin
        nxt.pstate = ST_DONE;
      end else if (at_limit) begin
        nxt.pstate = ST_LONG;
      end else begin
        unique case (cur.pstate)
          ST_START: begin
            if (ch == CH_SLASH) begin
              nxt.pstate = ST_PATH;
              nxt.slash  = 1'b1;
            end else begin
              nxt.pstate = ST_BAD;
            end
          end
          ST_PATH: begin
            if (ch == CH_PCT) begin
              nxt.pstate = ST_HEX1;
            end else if (ch == CH_QMARK) begin
              nxt.pstate = ST_QUERY;
              nxt.query  = 1'b1;
              nxt.slash  = 1'b0;
            end else if (ch == CH_SLASH) begin
              if (cur.slash) begin
                nxt.pstate = ST_BAD;
              end else begin
                nxt.slash = 1'b1;
              end
            end else if (pchar) begin
              nxt.slash = 1'b0;
            end else begin
              nxt.pstate = ST_BAD;
            end
          end
          ST_QUERY: begin
            if (ch == CH_PCT) begin
              nxt.pstate = ST_HEX1;
            end else if (!(ch == CH_SLASH || ch == CH_QMARK || pchar)) begin
              nxt.pstate = ST_BAD;
            end
          end
          ST_HEX1: begin
            if (hex[4]) begin
              nxt.hi_nib = hex[3:0];
              nxt.pstate = ST_HEX2;
            end else begin
              nxt.pstate = ST_BAD;
            end
          end
          ST_HEX2: begin
            if (hex[4]) begin
              nxt.slash  = 1'b0;
              nxt.pstate = cur.query ? ST_QUERY : ST_PATH;
            end else begin
              nxt.pstate = ST_BAD;
            end
          end
          default: nxt = cur;
        endcase
      end
    end
  end

  // result word
  always_comb begin
    logic emit;
    emit = 1'b0;
    res  = '{status: STAT_RUN, byte_valid: 1'b0, data_byte: 8'd0, in_query: 1'b0};
    unique case (cur.pstate)
      ST_START: emit = (ch == CH_SLASH);
      ST_PATH:  emit = (ch == CH_SLASH) ? !cur.slash :
                       (ch != CH_PCT && ch != CH_QMARK && pchar);
      ST_QUERY: emit = (ch == CH_SLASH || ch == CH_QMARK || pchar);
      ST_HEX2:  emit = hex[4];
      default:  emit = 1'b0;
    endcase
    if (!count_en) begin
      emit = 1'b0;
    end
    unique case (nxt.pstate)
      ST_DONE: res.status = terminal ? STAT_EXTRA : STAT_DONE;
      ST_BAD:  res.status = STAT_INVALID;
      ST_LONG: res.status = STAT_TOOLONG;
      default: res.status = STAT_RUN;
    endcase
    if (emit) begin
      res.byte_valid = 1'b1;
      res.data_byte  = (cur.pstate == ST_HEX2) ? {cur.hi_nib, hex[3:0]} : ch;
      res.in_query   = nxt.query;
    end
  end

endmodule
